@@ hw/rtl/chime_tone_led_sequencer_assert.svh @@
// Assertion helpers for the chime sequencer.
`ifndef CHIME_TONE_LED_SEQUENCER_ASSERT_SVH
`define CHIME_TONE_LED_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chime sequencer check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chime sequencer check failed");

`endif

@@ hw/rtl/cts_pkg.sv @@
package cts_pkg;

   // Command codes of a request.
   typedef enum logic [1:0] {
      CMD_PLAY  = 2'd0,
      CMD_TAG   = 2'd1,
      CMD_FOUND = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_ID_COOLDOWN    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_FOUND_COOLDOWN = 1'd1;

   // Mailbox code of a tag chirp; codes below it name event sequences.
   localparam logic [3:0] CHIRP_CODE  = 4'd8;
   localparam logic [7:0] CHIRP_LO_MS = 8'd65;
   localparam logic [7:0] CHIRP_HI_MS = 8'd55;
   localparam logic [9:0] CHIRP_LOCK  = 10'd220;
   localparam logic [3:0] CHIRP_STEPS = 4'd2;

   typedef struct packed {
      logic [12:0] f;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  d;
   } step_type;

   localparam logic [5:0] SEQ_FIRST [8] = '{6'd0, 6'd8, 6'd13, 6'd18,
                                            6'd24, 6'd33, 6'd38, 6'd42};
   localparam logic [3:0] SEQ_COUNT [8] = '{4'd8, 4'd5, 4'd5, 4'd6,
                                            4'd9, 4'd5, 4'd4, 4'd5};
   // Total step time of each sequence plus the 100 ms lock margin.
   localparam logic [9:0] SEQ_LOCK [8] = '{10'd598, 10'd398, 10'd523, 10'd810,
                                           10'd526, 10'd500, 10'd465, 10'd520};

   localparam logic [12:0] TAG_NOTE [16] = '{
      13'd262, 13'd330, 13'd392, 13'd440, 13'd523, 13'd659, 13'd784, 13'd880,
      13'd1047, 13'd1319, 13'd1568, 13'd1760, 13'd2093, 13'd2637, 13'd3136, 13'd3520};
   // Second chirp note: floor(note * 126 / 100).
   localparam logic [12:0] TAG_NOTE_HI [16] = '{
      13'd330, 13'd415, 13'd493, 13'd554, 13'd658, 13'd830, 13'd987, 13'd1108,
      13'd1319, 13'd1661, 13'd1975, 13'd2217, 13'd2637, 13'd3322, 13'd3951, 13'd4435};
   localparam logic [7:0] TAG_RED [16] = '{
      8'd255, 8'd255, 8'd220, 8'd80, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd100, 8'd200, 8'd255, 8'd255, 8'd200, 8'd150, 8'd0, 8'd120};
   localparam logic [7:0] TAG_GREEN [16] = '{
      8'd0, 8'd80, 8'd200, 8'd255, 8'd200, 8'd255, 8'd150, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd255, 8'd100, 8'd180, 8'd200, 8'd0};
   localparam logic [7:0] TAG_BLUE [16] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd180, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd150, 8'd255, 8'd0, 8'd0, 8'd150, 8'd200};

   // Step table of the eight event sequences.
   function automatic step_type cts_rom(input logic [5:0] addr);
      step_type st;
      case (addr)
         6'd0:  st = '{13'd659,  8'd0,   8'd120, 8'd180, 8'd70};
         6'd1:  st = '{13'd784,  8'd0,   8'd140, 8'd200, 8'd55};
         6'd2:  st = '{13'd988,  8'd0,   8'd140, 8'd200, 8'd55};
         6'd3:  st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd25};
         6'd4:  st = '{13'd1319, 8'd60,  8'd120, 8'd255, 8'd85};
         6'd5:  st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd18};
         6'd6:  st = '{13'd988,  8'd0,   8'd140, 8'd200, 8'd50};
         6'd7:  st = '{13'd1568, 8'd60,  8'd120, 8'd255, 8'd140};
         6'd8:  st = '{13'd784,  8'd0,   8'd180, 8'd50,  8'd60};
         6'd9:  st = '{13'd988,  8'd0,   8'd200, 8'd60,  8'd55};
         6'd10: st = '{13'd1319, 8'd0,   8'd255, 8'd80,  8'd85};
         6'd11: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd18};
         6'd12: st = '{13'd1568, 8'd0,   8'd255, 8'd80,  8'd80};
         6'd13: st = '{13'd880,  8'd200, 8'd100, 8'd0,   8'd80};
         6'd14: st = '{13'd784,  8'd180, 8'd70,  8'd0,   8'd75};
         6'd15: st = '{13'd659,  8'd200, 8'd30,  8'd0,   8'd100};
         6'd16: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd28};
         6'd17: st = '{13'd587,  8'd150, 8'd0,   8'd0,   8'd140};
         6'd18: st = '{13'd880,  8'd255, 8'd0,   8'd0,   8'd140};
         6'd19: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd110};
         6'd20: st = '{13'd880,  8'd255, 8'd0,   8'd0,   8'd140};
         6'd21: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd110};
         6'd22: st = '{13'd880,  8'd255, 8'd0,   8'd0,   8'd140};
         6'd23: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd70};
         6'd24: st = '{13'd1319, 8'd200, 8'd180, 8'd0,   8'd50};
         6'd25: st = '{13'd1760, 8'd255, 8'd230, 8'd0,   8'd48};
         6'd26: st = '{13'd1319, 8'd200, 8'd180, 8'd0,   8'd38};
         6'd27: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd20};
         6'd28: st = '{13'd1760, 8'd255, 8'd230, 8'd0,   8'd55};
         6'd29: st = '{13'd2093, 8'd255, 8'd240, 8'd100, 8'd58};
         6'd30: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd22};
         6'd31: st = '{13'd1568, 8'd220, 8'd200, 8'd0,   8'd35};
         6'd32: st = '{13'd1760, 8'd255, 8'd230, 8'd0,   8'd100};
         6'd33: st = '{13'd880,  8'd0,   8'd80,  8'd255, 8'd75};
         6'd34: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd35};
         6'd35: st = '{13'd880,  8'd0,   8'd80,  8'd255, 8'd75};
         6'd36: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd35};
         6'd37: st = '{13'd1175, 8'd0,   8'd160, 8'd255, 8'd180};
         6'd38: st = '{13'd784,  8'd0,   8'd180, 8'd50,  8'd65};
         6'd39: st = '{13'd988,  8'd0,   8'd200, 8'd60,  8'd65};
         6'd40: st = '{13'd1319, 8'd0,   8'd220, 8'd70,  8'd65};
         6'd41: st = '{13'd1568, 8'd0,   8'd255, 8'd80,  8'd170};
         6'd42: st = '{13'd784,  8'd220, 8'd0,   8'd0,   8'd80};
         6'd43: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd40};
         6'd44: st = '{13'd784,  8'd220, 8'd0,   8'd0,   8'd80};
         6'd45: st = '{13'd0,    8'd0,   8'd0,   8'd0,   8'd40};
         6'd46: st = '{13'd587,  8'd140, 8'd0,   8'd0,   8'd180};
         default: st = '0;
      endcase
      return st;
   endfunction

   // Number of steps in the sequence for a mailbox code.
   function automatic logic [3:0] cts_seq_len(input logic [3:0] code);
      return (code == CHIRP_CODE) ? CHIRP_STEPS : SEQ_COUNT[code[2:0]];
   endfunction

   // LED lock length issued when the sequence for a mailbox code starts.
   function automatic logic [9:0] cts_seq_lock(input logic [3:0] code);
      return (code == CHIRP_CODE) ? CHIRP_LOCK : SEQ_LOCK[code[2:0]];
   endfunction

   // One step of a sequence: a table entry, or a chirp step built from the tag.
   function automatic step_type cts_step(input logic [3:0] code, input logic [3:0] tag,
                                         input logic [3:0] idx);
      step_type   st;
      logic [3:0] idx_c;
      if (code == CHIRP_CODE) begin
         if (idx == 4'd0) begin
            st = '{TAG_NOTE[tag], {1'b0, TAG_RED[tag][7:1]}, {1'b0, TAG_GREEN[tag][7:1]},
                   {1'b0, TAG_BLUE[tag][7:1]}, CHIRP_LO_MS};
         end else begin
            st = '{TAG_NOTE_HI[tag], TAG_RED[tag], TAG_GREEN[tag], TAG_BLUE[tag],
                   CHIRP_HI_MS};
         end
      end else begin
         idx_c = (idx < SEQ_COUNT[code[2:0]]) ? idx : 4'd0;
         st    = cts_rom(SEQ_FIRST[code[2:0]] + {2'b00, idx_c});
      end
      return st;
   endfunction

endpackage

@@ hw/rtl/cts_channels.sv @@
// Request channel: one command per request.
interface cts_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [2:0] event_code;
   logic [3:0] tag_number;

   modport source (output valid, output cmd, output event_code, output tag_number,
                   input ready);
   modport sink (input valid, input cmd, input event_code, input tag_number,
                 output ready);
endinterface

// Response channel: buzzer and LED state after each request.
interface cts_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] tone_hz;
   logic [7:0]  led_red;
   logic [7:0]  led_green;
   logic [7:0]  led_blue;
   logic [9:0]  led_lock_ms;
   logic        busy_res;
   logic        accepted;

   modport source (output valid, output tone_hz, output led_red, output led_green,
                   output led_blue, output led_lock_ms, output busy_res, output accepted,
                   input ready);
   modport sink (input valid, input tone_hz, input led_red, input led_green,
                 input led_blue, input led_lock_ms, input busy_res, input accepted,
                 output ready);
endinterface

@@ hw/rtl/chime_tone_led_sequencer.sv @@
// Channel    Direction  Payload
// req_chan   in         cmd, event_code, tag_number
// rsp_chan   out        tone_hz, led_red/green/blue, led_lock_ms, busy_res, accepted
// csr_*      in         csr_we, csr_index, csr_wdata (write only)
//
// One request is taken every cycle unless the response stalls; each gives one response
// via the execute stage and response registers. The tag time memory is read at accept
// and written by the execute stage; the last write is forwarded to the next request.
// Synchronous active-high reset; both cooldowns return to 1000 ms and all tag
// times read as zero until written. A stalled response holds the execute stage,
// and a new request is still taken in the cycle the response is taken.

`include "chime_tone_led_sequencer_assert.svh"

module chime_tone_led_sequencer #(
   parameter int NUM_TAGS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   cts_req_if.sink                        req_chan,
   cts_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [cts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_wdata
);
   import cts_pkg::*;

   localparam int TAG_AW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;

   // Configuration registers.
   logic [15:0] id_cool_ff, found_cool_ff;

   // Tag time memory with valid bits.
   logic [31:0]       tag_time_mem [NUM_TAGS];
   logic [NUM_TAGS-1:0] tag_vld_ff;
   logic [31:0]       rd_data_ff;
   logic              rd_vld_ff;
   logic [TAG_AW-1:0] rd_addr;
   logic              fwd_hit_ff;
   logic [31:0]       fwd_data_ff;
   logic              mem_we;

   // Execute stage registers.
   logic              s1_valid_ff;
   cmd_type           s1_cmd_ff;
   logic [2:0]        s1_event_ff;
   logic [3:0]        s1_tag_ff;
   logic [TAG_AW-1:0] s1_addr_ff;
   logic              s1_inrange_ff;
   logic              s1_fire, req_fire, req_inrange;

   // Sequencer state.
   logic [31:0] now_ff, now_in;
   logic [31:0] found_ff, found_in;
   logic        pend_vld_ff, pend_vld_in;
   logic [3:0]  pend_code_ff, pend_code_in;
   logic [3:0]  pend_tag_ff, pend_tag_in;
   logic        playing_ff, playing_in;
   logic [3:0]  play_code_ff, play_code_in;
   logic [3:0]  play_tag_ff, play_tag_in;
   logic [3:0]  step_idx_ff, step_idx_in;
   logic [7:0]  left_ff, left_in;
   logic [12:0] tone_ff, tone_in;
   logic [23:0] colour_ff, colour_in;
   logic [9:0]  lock_in;
   logic        acc_in;

   logic [31:0] last_tag;
   logic        tag_cool_ok;
   logic        ld;
   logic [3:0]  ld_code, ld_tag, ld_idx, idx_nx;
   step_type    st;

   // Response register.
   logic        rsp_valid_ff;
   logic [12:0] rsp_tone_ff;
   logic [23:0] rsp_colour_ff;
   logic [9:0]  rsp_lock_ff;
   logic        rsp_busy_ff, rsp_acc_ff;

   // Handshakes.
   assign s1_fire        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_inrange    = (int'(req_chan.tag_number) < NUM_TAGS);
   assign rd_addr        = req_inrange ? req_chan.tag_number[TAG_AW-1:0] : '0;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_cool_ff    <= 16'd1000;
         found_cool_ff <= 16'd1000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAG_ID_COOLDOWN:    id_cool_ff    <= csr_wdata;
            CSR_TAG_FOUND_COOLDOWN: found_cool_ff <= csr_wdata;
         endcase
      end
   end

   // Memory read at accept, and write from the execute stage.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff  <= tag_time_mem[rd_addr];
         fwd_data_ff <= now_ff;
      end
      if (mem_we) begin
         tag_time_mem[s1_addr_ff] <= now_ff;
      end
   end

   // Valid bits and forwarding flag; the flag catches a write to the entry being read.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            rd_vld_ff  <= tag_vld_ff[rd_addr];
            fwd_hit_ff <= mem_we && (s1_addr_ff == rd_addr);
         end
         if (mem_we) begin
            tag_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   // Execute stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff     <= cmd_type'(req_chan.cmd);
         s1_event_ff   <= req_chan.event_code;
         s1_tag_ff     <= req_chan.tag_number;
         s1_addr_ff    <= rd_addr;
         s1_inrange_ff <= req_inrange;
      end
   end

   // Last chirp time of the tag, with the newest write taking priority.
   assign last_tag    = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : 32'd0);
   assign tag_cool_ok = s1_inrange_ff && ((now_ff - last_tag) >= {16'd0, id_cool_ff});
   assign mem_we      = s1_fire && (s1_cmd_ff == CMD_TAG) && tag_cool_ok;
   assign st          = cts_step(ld_code, ld_tag, ld_idx);

   // Command decode and sequence stepping.
   always_comb begin
      now_in       = now_ff;
      found_in     = found_ff;
      pend_vld_in  = pend_vld_ff;
      pend_code_in = pend_code_ff;
      pend_tag_in  = pend_tag_ff;
      playing_in   = playing_ff;
      play_code_in = play_code_ff;
      play_tag_in  = play_tag_ff;
      step_idx_in  = step_idx_ff;
      left_in      = left_ff;
      tone_in      = tone_ff;
      colour_in    = colour_ff;
      lock_in      = 10'd0;
      acc_in       = 1'b0;
      ld           = 1'b0;
      ld_code      = play_code_ff;
      ld_tag       = play_tag_ff;
      idx_nx       = step_idx_ff + 4'd1;
      ld_idx       = idx_nx;
      case (s1_cmd_ff)
         CMD_PLAY: begin
            pend_vld_in  = 1'b1;
            pend_code_in = {1'b0, s1_event_ff};
            pend_tag_in  = 4'd0;
            acc_in       = 1'b1;
         end
         CMD_TAG: begin
            if (tag_cool_ok && !pend_vld_ff) begin
               pend_vld_in  = 1'b1;
               pend_code_in = CHIRP_CODE;
               pend_tag_in  = s1_tag_ff;
               acc_in       = 1'b1;
            end
         end
         CMD_FOUND: begin
            if ((now_ff - found_ff) >= {16'd0, found_cool_ff}) begin
               pend_vld_in  = 1'b1;
               pend_code_in = 4'd4;
               pend_tag_in  = 4'd0;
               acc_in       = 1'b1;
            end
            found_in = now_ff;
         end
         default: begin
            now_in = now_ff + 32'd1;
            if (pend_vld_ff) begin
               // A pending command aborts the current sequence and starts its own.
               pend_vld_in  = 1'b0;
               play_code_in = pend_code_ff;
               play_tag_in  = pend_tag_ff;
               lock_in      = cts_seq_lock(pend_code_ff);
               step_idx_in  = 4'd0;
               playing_in   = 1'b1;
               ld           = 1'b1;
               ld_code      = pend_code_ff;
               ld_tag       = pend_tag_ff;
               ld_idx       = 4'd0;
            end else if (playing_ff) begin
               if (left_ff <= 8'd1) begin
                  if (idx_nx >= cts_seq_len(play_code_ff)) begin
                     // End of sequence: buzzer off, LED keeps its color.
                     playing_in  = 1'b0;
                     step_idx_in = 4'd0;
                     left_in     = 8'd0;
                     tone_in     = 13'd0;
                  end else begin
                     step_idx_in = idx_nx;
                     ld          = 1'b1;
                  end
               end else begin
                  left_in = left_ff - 8'd1;
               end
            end
         end
      endcase
      if (ld) begin
         tone_in   = st.f;
         colour_in = {st.r, st.g, st.b};
         left_in   = st.d;
      end
   end

   // Sequencer state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= 32'd0;
         found_ff     <= 32'd0;
         pend_vld_ff  <= 1'b0;
         pend_code_ff <= 4'd0;
         pend_tag_ff  <= 4'd0;
         playing_ff   <= 1'b0;
         play_code_ff <= 4'd0;
         play_tag_ff  <= 4'd0;
         step_idx_ff  <= 4'd0;
         left_ff      <= 8'd0;
         tone_ff      <= 13'd0;
         colour_ff    <= 24'd0;
      end else if (s1_fire) begin
         now_ff       <= now_in;
         found_ff     <= found_in;
         pend_vld_ff  <= pend_vld_in;
         pend_code_ff <= pend_code_in;
         pend_tag_ff  <= pend_tag_in;
         playing_ff   <= playing_in;
         play_code_ff <= play_code_in;
         play_tag_ff  <= play_tag_in;
         step_idx_ff  <= step_idx_in;
         left_ff      <= left_in;
         tone_ff      <= tone_in;
         colour_ff    <= colour_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_tone_ff   <= tone_in;
         rsp_colour_ff <= colour_in;
         rsp_lock_ff   <= lock_in;
         rsp_busy_ff   <= playing_in;
         rsp_acc_ff    <= acc_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tone_hz     = rsp_tone_ff;
   assign rsp_chan.led_red     = rsp_colour_ff[23:16];
   assign rsp_chan.led_green   = rsp_colour_ff[15:8];
   assign rsp_chan.led_blue    = rsp_colour_ff[7:0];
   assign rsp_chan.led_lock_ms = rsp_lock_ff;
   assign rsp_chan.busy_res    = rsp_busy_ff;
   assign rsp_chan.accepted    = rsp_acc_ff;

   // Checks on the sequencer and the memory forwarding.
   `CTS_ASSERT_NOW(a_play_has_time, clock, reset, playing_ff, left_ff != 8'd0)
   `CTS_ASSERT_NOW(a_idle_quiet, clock, reset, !playing_ff, tone_ff == 13'd0)
   `CTS_ASSERT_NOW(a_lock_busy, clock, reset,
                   rsp_valid_ff && (rsp_lock_ff != 10'd0), rsp_busy_ff)
   `CTS_ASSERT_NEXT(a_fwd_catch, clock, reset,
                    mem_we && req_fire && (s1_addr_ff == rd_addr), fwd_hit_ff)

endmodule
